>>> rtl/bba_pkg.sv
// shared constants, payload structs and sequencer states of the buddy allocator
package bba_pkg;

   localparam int UNIT_ORDER = 5;
   localparam int HEAP_ORDER = 16;
   localparam int NUM_ORDERS = HEAP_ORDER - UNIT_ORDER + 1;
   localparam int UNIT_W     = HEAP_ORDER - UNIT_ORDER;
   localparam int NUM_UNITS  = 1 << UNIT_W;
   localparam int OIDX_W     = $clog2(NUM_ORDERS);
   localparam int ORDER_W    = 5;
   localparam int BYTES_W    = 24;
   localparam int REQ_W      = BYTES_W + 1;
   localparam int ADDR_W     = 16;
   localparam int STATUS_W   = 3;
   localparam int HDR_BYTES  = 2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_ZERO_SIZE = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_TOO_LARGE = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_NO_MEMORY = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_NOT_ALLOC = 3'd4;

   typedef struct packed {
      logic               op;
      logic [BYTES_W-1:0] request_bytes;
      logic [ADDR_W-1:0]  freed_address;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   granted_address;
      logic [ORDER_W-1:0]  block_order;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      logic [UNIT_W-1:0] unit;
   } link_type;

   typedef struct packed {
      logic [ORDER_W-1:0] alloc_order;
      logic [ORDER_W-1:0] free_order;
   } mark_type;

   localparam link_type LINK_NULL = '{valid: 1'b0, unit: '0};

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_A_UNLINK,
      ST_A_SPLIT,
      ST_PUSH_B,
      ST_F_LOOK,
      ST_F_CHECK,
      ST_F_BUDDY,
      ST_F_UNLINK,
      ST_F_PUSH
   } state_type;

endpackage

>>> rtl/bba_ram.sv
// generic single-write, single-read synchronous ram with registered read data
module bba_ram #(
   parameter int DATA_W = 8,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [(1 << ADDR_W)];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/binary_buddy_allocator.sv
// binary buddy allocator: top level with the list sequencer and its memories
//
// heap of 64 KiB in 2048 units of 32 bytes, orders 5 to 16. a beat is taken when
// start is high and busy is low; its one result appears on rsp_data for exactly
// one cycle with rsp_strobe and cannot be held off. after reset the block runs a
// clearing pass over the 2048-entry mark memory and stays busy until it is done.
// an allocate takes one split step per order above the target, a free one merge
// step per free buddy, stopping at the top order; failures answer without these
// steps. the sequence is set by the single read port and registered read data of
// the link and mark memories, visited one list operation at a time.
module binary_buddy_allocator (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bba_pkg::req_type req_data,
   output logic             rsp_strobe,
   output bba_pkg::rsp_type rsp_data
);

   // sequencer registers
   bba_pkg::state_type state_ff, state_in;
   logic                          op_ff, op_in;
   logic [bba_pkg::UNIT_W-1:0]    u_ff, u_in;
   logic [bba_pkg::UNIT_W-1:0]    pu_ff, pu_in;
   logic [bba_pkg::ORDER_W-1:0]   ord_ff, ord_in;
   logic [bba_pkg::ORDER_W-1:0]   tgt_ff, tgt_in;
   bba_pkg::link_type             hd_ff, hd_in;
   logic [bba_pkg::UNIT_W-1:0]    clr_ff, clr_in;
   bba_pkg::link_type             heads_ff [bba_pkg::NUM_ORDERS];
   bba_pkg::link_type             heads_in [bba_pkg::NUM_ORDERS];
   bba_pkg::rsp_type              rsp_ff, rsp_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   // memory ports
   logic                       nxt_we, prv_we, mrk_we;
   logic [bba_pkg::UNIT_W-1:0] nxt_wa, prv_wa, mrk_wa;
   logic [bba_pkg::UNIT_W-1:0] nxt_ra, prv_ra, mrk_ra;
   bba_pkg::link_type          nxt_wd, prv_wd, nxt_rd, prv_rd;
   bba_pkg::mark_type          mrk_wd, mrk_rd;

   // decode
   logic                         accept;
   logic [bba_pkg::OIDX_W-1:0]   ord_idx, split_idx, tgt_idx, fidx;
   logic [bba_pkg::UNIT_W-1:0]   bit_mask, buddy, split_unit, funit;
   logic [bba_pkg::ORDER_W-1:0]  split_ord, target;
   logic [bba_pkg::REQ_W-1:0]    required;
   logic                         zero_size, too_large, found, fbad;
   logic [bba_pkg::ADDR_W-1:0]   foff;
   logic                         more_split, can_merge, buddy_hit;
   logic [bba_pkg::ADDR_W-1:0]   u_addr;

   assign accept = start && (state_ff == bba_pkg::ST_IDLE);
   assign busy   = (state_ff != bba_pkg::ST_IDLE);

   always_comb begin
      ord_idx    = bba_pkg::OIDX_W'(ord_ff - bba_pkg::ORDER_W'(bba_pkg::UNIT_ORDER));
      split_idx  = ord_idx - bba_pkg::OIDX_W'(1);
      split_ord  = ord_ff - bba_pkg::ORDER_W'(1);
      bit_mask   = bba_pkg::UNIT_W'(1) << ord_idx;
      buddy      = u_ff ^ bit_mask;
      split_unit = u_ff | (bba_pkg::UNIT_W'(1) << split_idx);
      more_split = (ord_ff > tgt_ff);
      can_merge  = (ord_ff < bba_pkg::ORDER_W'(bba_pkg::HEAP_ORDER));
      buddy_hit  = (mrk_rd.free_order == ord_ff);
      u_addr     = bba_pkg::ADDR_W'({u_ff, {bba_pkg::UNIT_ORDER{1'b0}}})
                   + bba_pkg::ADDR_W'(bba_pkg::HDR_BYTES);

      // allocate: header added, rounded up to an order of at least the minimum
      zero_size = (req_data.request_bytes == '0);
      required  = {1'b0, req_data.request_bytes} + bba_pkg::REQ_W'(bba_pkg::HDR_BYTES);
      too_large = (required > (bba_pkg::REQ_W'(1) << bba_pkg::HEAP_ORDER));
      target    = bba_pkg::ORDER_W'(bba_pkg::HEAP_ORDER);
      for (int o = bba_pkg::HEAP_ORDER; o >= bba_pkg::UNIT_ORDER; o--) begin
         if (required <= (bba_pkg::REQ_W'(1) << o)) begin
            target = bba_pkg::ORDER_W'(o);
         end
      end
      tgt_idx = bba_pkg::OIDX_W'(target - bba_pkg::ORDER_W'(bba_pkg::UNIT_ORDER));

      // smallest non-empty list at or above the target
      found = 1'b0;
      fidx  = '0;
      for (int i = bba_pkg::NUM_ORDERS - 1; i >= 0; i--) begin
         if (heads_ff[i].valid && (bba_pkg::OIDX_W'(i) >= tgt_idx)) begin
            found = 1'b1;
            fidx  = bba_pkg::OIDX_W'(i);
         end
      end

      // free: address must sit two bytes past a unit boundary
      foff  = req_data.freed_address - bba_pkg::ADDR_W'(bba_pkg::HDR_BYTES);
      fbad  = (req_data.freed_address < bba_pkg::ADDR_W'(bba_pkg::HDR_BYTES))
              || (foff[bba_pkg::UNIT_ORDER-1:0] != '0);
      funit = bba_pkg::UNIT_W'(foff >> bba_pkg::UNIT_ORDER);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bba_pkg::ST_CLEAR: begin
            if (clr_ff == bba_pkg::UNIT_W'(bba_pkg::NUM_UNITS - 1)) begin
               state_in = bba_pkg::ST_IDLE;
            end
         end
         bba_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_data.op == bba_pkg::OP_ALLOC) begin
                  if (!zero_size && !too_large && found) begin
                     state_in = bba_pkg::ST_A_UNLINK;
                  end
               end else if (!fbad) begin
                  state_in = bba_pkg::ST_F_LOOK;
               end
            end
         end
         bba_pkg::ST_A_UNLINK: state_in = bba_pkg::ST_A_SPLIT;
         bba_pkg::ST_A_SPLIT:  state_in = more_split ? bba_pkg::ST_PUSH_B : bba_pkg::ST_IDLE;
         bba_pkg::ST_PUSH_B: begin
            state_in = (op_ff == bba_pkg::OP_FREE) ? bba_pkg::ST_IDLE : bba_pkg::ST_A_SPLIT;
         end
         bba_pkg::ST_F_LOOK: begin
            state_in = (mrk_rd.alloc_order == '0) ? bba_pkg::ST_IDLE : bba_pkg::ST_F_CHECK;
         end
         bba_pkg::ST_F_CHECK:  state_in = can_merge ? bba_pkg::ST_F_BUDDY : bba_pkg::ST_F_PUSH;
         bba_pkg::ST_F_BUDDY:  state_in = buddy_hit ? bba_pkg::ST_F_UNLINK : bba_pkg::ST_F_PUSH;
         bba_pkg::ST_F_UNLINK: state_in = bba_pkg::ST_F_CHECK;
         bba_pkg::ST_F_PUSH:   state_in = bba_pkg::ST_PUSH_B;
         default:              state_in = bba_pkg::ST_CLEAR;
      endcase
   end

   // datapath registers and memory ports
   always_comb begin
      op_in        = op_ff;
      u_in         = u_ff;
      pu_in        = pu_ff;
      ord_in       = ord_ff;
      tgt_in       = tgt_ff;
      hd_in        = hd_ff;
      clr_in       = clr_ff;
      heads_in     = heads_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;

      nxt_we = 1'b0;
      nxt_wa = u_ff;
      nxt_wd = bba_pkg::LINK_NULL;
      prv_we = 1'b0;
      prv_wa = u_ff;
      prv_wd = bba_pkg::LINK_NULL;
      mrk_we = 1'b0;
      mrk_wa = u_ff;
      mrk_wd = '0;

      nxt_ra = (state_ff == bba_pkg::ST_IDLE) ? heads_ff[fidx].unit : buddy;
      prv_ra = buddy;
      mrk_ra = (state_ff == bba_pkg::ST_IDLE) ? funit : buddy;

      case (state_ff)
         bba_pkg::ST_CLEAR: begin
            // marks all cleared, unit 0 listed free at the top order
            mrk_we = 1'b1;
            mrk_wa = clr_ff;
            if (clr_ff == '0) begin
               mrk_wd.free_order = bba_pkg::ORDER_W'(bba_pkg::HEAP_ORDER);
               nxt_we = 1'b1;
               nxt_wa = '0;
               prv_we = 1'b1;
               prv_wa = '0;
            end
            clr_in = clr_ff + bba_pkg::UNIT_W'(1);
         end
         bba_pkg::ST_IDLE: begin
            if (accept) begin
               op_in                  = req_data.op;
               rsp_in.granted_address = '0;
               rsp_in.block_order     = '0;
               if (req_data.op == bba_pkg::OP_ALLOC) begin
                  tgt_in = target;
                  ord_in = bba_pkg::ORDER_W'(fidx) + bba_pkg::ORDER_W'(bba_pkg::UNIT_ORDER);
                  u_in   = heads_ff[fidx].unit;
                  if (zero_size) begin
                     rsp_in.status = bba_pkg::STAT_ZERO_SIZE;
                     rsp_valid_in  = 1'b1;
                  end else if (too_large) begin
                     rsp_in.status = bba_pkg::STAT_TOO_LARGE;
                     rsp_valid_in  = 1'b1;
                  end else if (!found) begin
                     rsp_in.status = bba_pkg::STAT_NO_MEMORY;
                     rsp_valid_in  = 1'b1;
                  end
               end else begin
                  u_in = funit;
                  if (fbad) begin
                     rsp_in.status = bba_pkg::STAT_NOT_ALLOC;
                     rsp_valid_in  = 1'b1;
                  end
               end
            end
         end
         bba_pkg::ST_A_UNLINK: begin
            // the taken block is its list's head: its successor becomes head
            heads_in[ord_idx] = nxt_rd;
            if (nxt_rd.valid) begin
               prv_we = 1'b1;
               prv_wa = nxt_rd.unit;
               prv_wd = bba_pkg::LINK_NULL;
            end
            mrk_we = 1'b1;
            mrk_wa = u_ff;
            mrk_wd = '0;
         end
         bba_pkg::ST_A_SPLIT: begin
            if (more_split) begin
               // push the upper half onto the list one order down
               nxt_we              = 1'b1;
               nxt_wa              = split_unit;
               nxt_wd              = heads_ff[split_idx];
               prv_we              = 1'b1;
               prv_wa              = split_unit;
               prv_wd              = bba_pkg::LINK_NULL;
               mrk_we              = 1'b1;
               mrk_wa              = split_unit;
               mrk_wd.free_order   = split_ord;
               hd_in               = heads_ff[split_idx];
               heads_in[split_idx] = '{valid: 1'b1, unit: split_unit};
               pu_in               = split_unit;
               ord_in              = split_ord;
            end else begin
               mrk_we                 = 1'b1;
               mrk_wa                 = u_ff;
               mrk_wd.alloc_order     = tgt_ff;
               rsp_in.status          = bba_pkg::STAT_OK;
               rsp_in.granted_address = u_addr;
               rsp_in.block_order     = tgt_ff;
               rsp_valid_in           = 1'b1;
            end
         end
         bba_pkg::ST_PUSH_B: begin
            // back link from the old head to the new one
            if (hd_ff.valid) begin
               prv_we = 1'b1;
               prv_wa = hd_ff.unit;
               prv_wd = '{valid: 1'b1, unit: pu_ff};
            end
            if (op_ff == bba_pkg::OP_FREE) begin
               rsp_in.status          = bba_pkg::STAT_OK;
               rsp_in.granted_address = u_addr;
               rsp_in.block_order     = ord_ff;
               rsp_valid_in           = 1'b1;
            end
         end
         bba_pkg::ST_F_LOOK: begin
            if (mrk_rd.alloc_order == '0) begin
               rsp_in.status          = bba_pkg::STAT_NOT_ALLOC;
               rsp_in.granted_address = '0;
               rsp_in.block_order     = '0;
               rsp_valid_in           = 1'b1;
            end else begin
               ord_in = mrk_rd.alloc_order;
               mrk_we = 1'b1;
               mrk_wa = u_ff;
               mrk_wd = '0;
            end
         end
         bba_pkg::ST_F_UNLINK: begin
            // take the free buddy out of its list and merge upward
            if (prv_rd.valid) begin
               nxt_we = 1'b1;
               nxt_wa = prv_rd.unit;
               nxt_wd = nxt_rd;
            end else begin
               heads_in[ord_idx] = nxt_rd;
            end
            if (nxt_rd.valid) begin
               prv_we = 1'b1;
               prv_wa = nxt_rd.unit;
               prv_wd = prv_rd;
            end
            mrk_we = 1'b1;
            mrk_wa = buddy;
            mrk_wd = '0;
            u_in   = u_ff & ~bit_mask;
            ord_in = ord_ff + bba_pkg::ORDER_W'(1);
         end
         bba_pkg::ST_F_PUSH: begin
            nxt_we            = 1'b1;
            nxt_wa            = u_ff;
            nxt_wd            = heads_ff[ord_idx];
            prv_we            = 1'b1;
            prv_wa            = u_ff;
            prv_wd            = bba_pkg::LINK_NULL;
            mrk_we            = 1'b1;
            mrk_wa            = u_ff;
            mrk_wd.free_order = ord_ff;
            hd_in             = heads_ff[ord_idx];
            heads_in[ord_idx] = '{valid: 1'b1, unit: u_ff};
            pu_in             = u_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bba_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         // only the top order starts out holding a block
         for (int i = 0; i < bba_pkg::NUM_ORDERS; i++) begin
            if (i == bba_pkg::NUM_ORDERS - 1) begin
               heads_ff[i] <= '{valid: 1'b1, unit: '0};
            end else begin
               heads_ff[i] <= bba_pkg::LINK_NULL;
            end
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         heads_ff     <= heads_in;
      end
      op_ff  <= op_in;
      u_ff   <= u_in;
      pu_ff  <= pu_in;
      ord_ff <= ord_in;
      tgt_ff <= tgt_in;
      hd_ff  <= hd_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // forward links
   bba_ram #(.DATA_W($bits(bba_pkg::link_type)), .ADDR_W(bba_pkg::UNIT_W)) u_next_ram (
      .clock   (clock),
      .wr_en   (nxt_we),
      .wr_addr (nxt_wa),
      .wr_data (nxt_wd),
      .rd_addr (nxt_ra),
      .rd_data (nxt_rd)
   );

   // backward links
   bba_ram #(.DATA_W($bits(bba_pkg::link_type)), .ADDR_W(bba_pkg::UNIT_W)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prv_we),
      .wr_addr (prv_wa),
      .wr_data (prv_wd),
      .rd_addr (prv_ra),
      .rd_data (prv_rd)
   );

   // allocated and free order marks per unit
   bba_ram #(.DATA_W($bits(bba_pkg::mark_type)), .ADDR_W(bba_pkg::UNIT_W)) u_mark_ram (
      .clock   (clock),
      .wr_en   (mrk_we),
      .wr_addr (mrk_wa),
      .wr_data (mrk_wd),
      .rd_addr (mrk_ra),
      .rd_data (mrk_rd)
   );

endmodule
